[src/sst_pkg.sv]
package sst_pkg;

    localparam int OFF_W = 32;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_SLASH = 4'd1,
        M_LINE  = 4'd2,
        M_BLOCK = 4'd3,
        M_STR   = 4'd4,
        M_NUM   = 4'd5,
        M_IDENT = 4'd6,
        M_OP    = 4'd7,
        M_DOT   = 4'd8
    } t_mode;

    // number phases
    localparam logic [3:0] PH_ZERO  = 4'd0;
    localparam logic [3:0] PH_HEX0  = 4'd1;
    localparam logic [3:0] PH_HEX   = 4'd2;
    localparam logic [3:0] PH_DEC   = 4'd3;
    localparam logic [3:0] PH_FRAC  = 4'd4;
    localparam logic [3:0] PH_ECHK  = 4'd5;
    localparam logic [3:0] PH_E     = 4'd6;
    localparam logic [3:0] PH_ESIGN = 4'd7;
    localparam logic [3:0] PH_EXP   = 4'd8;
    localparam logic [3:0] PH_SUF   = 4'd9;
    localparam logic [3:0] PH_GLUE  = 4'd10;

    // line kinds
    localparam logic [1:0] LK_NONE = 2'd0;
    localparam logic [1:0] LK_DOC  = 2'd1;
    localparam logic [1:0] LK_DIR  = 2'd2;

    // token kinds
    localparam logic [3:0] K_INT   = 4'd0;
    localparam logic [3:0] K_FLOAT = 4'd1;
    localparam logic [3:0] K_STR   = 4'd2;
    localparam logic [3:0] K_IDENT = 4'd3;
    localparam logic [3:0] K_OP    = 4'd4;
    localparam logic [3:0] K_DIR   = 4'd5;
    localparam logic [3:0] K_DOC   = 4'd6;
    localparam logic [3:0] K_UNK   = 4'd7;
    localparam logic [3:0] K_EOF   = 4'd8;
    localparam logic [3:0] K_DIAG  = 4'd9;

    // error codes
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_UNK     = 3'd1;
    localparam logic [2:0] E_OPENCMT = 3'd2;
    localparam logic [2:0] E_OPENSTR = 3'd3;
    localparam logic [2:0] E_BADESC  = 3'd4;
    localparam logic [2:0] E_BADNUM  = 3'd5;
    localparam logic [2:0] E_HASH    = 3'd6;

    // number flags
    localparam int F_HEX = 0;
    localparam int F_FE  = 1;
    localparam int F_BAD = 2;
    localparam int F_FS  = 3;
    localparam int F_IS  = 4;
    localparam int F_U   = 5;

    // selected operator codes
    localparam logic [5:0] OP_SHL_EQ = 6'd0;
    localparam logic [5:0] OP_SHR_EQ = 6'd1;
    localparam logic [5:0] OP_DIV_EQ = 6'd13;
    localparam logic [5:0] OP_SHL    = 6'd18;
    localparam logic [5:0] OP_SHR    = 6'd19;
    localparam logic [5:0] OP_DOT    = 6'd29;
    localparam logic [5:0] OP_DIV    = 6'd34;

    localparam logic [1:0] CFG_DOC = 2'd0;
    localparam logic [1:0] CFG_DIR = 2'd1;

    // one token record, offsets kept at full port width
    typedef struct packed {
        logic [3:0]  kind;
        logic [5:0]  op;
        logic [31:0] start;
        logic [31:0] len;
        logic        ls;
        logic [63:0] val;
        logic        uns;
        logic [2:0]  err;
    } t_rec;

    // up to three records produced by one request
    typedef struct packed {
        logic [1:0] n;
        t_rec       r0;
        t_rec       r1;
        t_rec       r2;
    } t_bundle;

    function automatic logic is_digit(input logic [15:0] c);
        return c >= 16'h30 && c <= 16'h39;
    endfunction
    function automatic logic is_alpha(input logic [15:0] c);
        return (c >= 16'h61 && c <= 16'h7a) || (c >= 16'h41 && c <= 16'h5a) || c == 16'h5f;
    endfunction
    function automatic logic is_idc(input logic [15:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction
    function automatic logic is_hexd(input logic [15:0] c);
        return is_digit(c) || (c >= 16'h61 && c <= 16'h66) || (c >= 16'h41 && c <= 16'h46);
    endfunction
    function automatic logic [3:0] hex_val(input logic [15:0] c);
        logic [15:0] t;
        if (is_digit(c)) t = c - 16'h30;
        else if (c >= 16'h61) t = c - 16'h57;
        else t = c - 16'h37;
        return t[3:0];
    endfunction
    function automatic logic is_fsuf(input logic [15:0] c);
        return c == 16'h66 || c == 16'h46 || c == 16'h68 || c == 16'h48;
    endfunction
    function automatic logic is_usuf(input logic [15:0] c);
        return c == 16'h75 || c == 16'h55;
    endfunction
    function automatic logic is_suffix(input logic [15:0] c);
        return is_fsuf(c) || is_usuf(c) || c == 16'h6c || c == 16'h4c;
    endfunction
    function automatic logic is_eol(input logic [15:0] c);
        return c == 16'h0a || c == 16'h0d;
    endfunction
    function automatic logic is_space(input logic [15:0] c);
        return c == 16'h20 || c == 16'h09 || c == 16'h0b || c == 16'h0c;
    endfunction
    function automatic logic good_escape(input logic [15:0] c);
        return c == 16'h5c || c == 16'h22 || c == 16'h6e || c == 16'h72 ||
               c == 16'h74 || c == 16'h30;
    endfunction

    // single-character operator code, 63 when none
    function automatic logic [5:0] op1(input logic [15:0] c);
        case (c)
            16'h28: return 6'd20;
            16'h29: return 6'd21;
            16'h7b: return 6'd22;
            16'h7d: return 6'd23;
            16'h5b: return 6'd24;
            16'h5d: return 6'd25;
            16'h2c: return 6'd26;
            16'h3b: return 6'd27;
            16'h3a: return 6'd28;
            16'h2e: return 6'd29;
            16'h3f: return 6'd30;
            16'h2b: return 6'd31;
            16'h2d: return 6'd32;
            16'h2a: return 6'd33;
            16'h2f: return 6'd34;
            16'h25: return 6'd35;
            16'h26: return 6'd36;
            16'h7c: return 6'd37;
            16'h5e: return 6'd38;
            16'h7e: return 6'd39;
            16'h21: return 6'd40;
            16'h3c: return 6'd41;
            16'h3e: return 6'd42;
            16'h3d: return 6'd43;
            default: return 6'd63;
        endcase
    endfunction

    // two-character operator code (not shifts), 63 when none
    function automatic logic [5:0] op2(input logic [7:0] a, input logic [15:0] b);
        logic [5:0] k;
        k = 6'd63;
        if (b == 16'h3d) begin
            case (a)
                8'h3d: k = 6'd6;
                8'h21: k = 6'd7;
                8'h3c: k = 6'd8;
                8'h3e: k = 6'd9;
                8'h2b: k = 6'd10;
                8'h2d: k = 6'd11;
                8'h2a: k = 6'd12;
                8'h2f: k = 6'd13;
                8'h25: k = 6'd14;
                8'h26: k = 6'd15;
                8'h7c: k = 6'd16;
                8'h5e: k = 6'd17;
                default: k = 6'd63;
            endcase
        end else if (b[15:8] == 8'h00 && b[7:0] == a) begin
            case (a)
                8'h2b: k = 6'd2;
                8'h2d: k = 6'd3;
                8'h26: k = 6'd4;
                8'h7c: k = 6'd5;
                default: k = 6'd63;
            endcase
        end
        return k;
    endfunction

    function automatic logic has_longer(input logic [15:0] c);
        return c == 16'h3c || c == 16'h3e || c == 16'h2b || c == 16'h2d || c == 16'h26 ||
               c == 16'h7c || c == 16'h3d || c == 16'h21 || c == 16'h2a || c == 16'h2f ||
               c == 16'h25 || c == 16'h5e;
    endfunction

endpackage

[src/sst_if.sv]
interface sst_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        end_of_text;
    modport source (output valid, char_code, end_of_text, input ready);
    modport sink (input valid, char_code, end_of_text, output ready);
endinterface

interface sst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [5:0]  operator_code;
    logic [31:0] span_start;
    logic [31:0] span_length;
    logic        at_line_start;
    logic [63:0] integer_value;
    logic        is_unsigned;
    logic [2:0]  error_code;
    logic        last_of_run;
    modport source (output valid, token_kind, operator_code, span_start, span_length,
                    at_line_start, integer_value, is_unsigned, error_code, last_of_run,
                    input ready);
    modport sink (input valid, token_kind, operator_code, span_start, span_length,
                  at_line_start, integer_value, is_unsigned, error_code, last_of_run,
                  output ready);
endinterface

[src/sst_front.sv]
// Lexer front: classifies each code unit and forms up to three records per request.
module sst_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [15:0]          i_c,
    input  logic                 i_last,
    input  logic                 i_doc_en,
    input  logic                 i_dir_en,
    output sst_pkg::t_bundle     o_bundle
);
    import sst_pkg::*;

    t_mode                  r_mode, n_mode;
    logic                   r_ls, n_ls;
    logic [OFFSET_BITS-1:0] r_tstart, n_tstart;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [63:0]            r_acc, n_acc;
    logic [5:0]             r_nf, n_nf;
    logic [15:0]            r_pc0, n_pc0;
    logic [1:0]             r_pcnt, n_pcnt;

    t_bundle b;

    // offset widening to the 32-bit record fields
    function automatic logic [31:0] wo(input logic [OFFSET_BITS-1:0] x);
        return 32'(x);
    endfunction

    always_comb begin
        t_mode                  m;
        logic                   ls;
        logic [OFFSET_BITS-1:0] ts, p, p1;
        logic [63:0]            acc;
        logic [5:0]             nf, f;
        logic [15:0]            pc0;
        logic [1:0]             pcnt;
        logic [3:0]             ph;
        logic                   redo, done, isf;
        logic [5:0]             k;
        logic [1:0]             n;
        t_rec                   rec [3];
        int                     it, j;

        m = r_mode; ls = r_ls; ts = r_tstart; acc = r_acc; nf = r_nf;
        pc0 = r_pc0; pcnt = r_pcnt;
        p = r_pos;
        p1 = p + 1'b1;
        n = 2'd0;
        for (j = 0; j < 3; j++) rec[j] = '0;
        ph = 4'd0; f = '0; isf = 1'b0; k = '0; done = 1'b0;

        // at most three passes: a mode ends, then the unit is re-examined
        redo = 1'b1;
        for (it = 0; it < 3; it++) begin
            if (redo) begin
                redo = 1'b0;
                case (m)
                    M_IDLE: begin
                        if (is_eol(i_c)) ls = 1'b1;
                        else if (!is_space(i_c)) begin
                            ts = p;
                            if (i_c == 16'h2f) m = M_SLASH;
                            else if (i_c == 16'h23) begin
                                if (!ls) begin
                                    rec[n] = '{K_UNK, 6'd0, wo(p), 32'd1, 1'b0, 64'd0, 1'b0,
                                               E_HASH};
                                    n = n + 1'b1;
                                end else begin
                                    m = M_LINE; pc0 = 16'(LK_DIR); pcnt = 2'd0;
                                end
                            end else if (i_c == 16'h22) begin
                                m = M_STR; pcnt = 2'd0;
                            end else if (is_digit(i_c)) begin
                                m = M_NUM; acc = 64'(i_c - 16'h30); nf = '0;
                                pc0 = (i_c == 16'h30) ? 16'(PH_ZERO) : 16'(PH_DEC);
                            end else if (i_c == 16'h2e) m = M_DOT;
                            else if (is_alpha(i_c)) m = M_IDENT;
                            else if (op1(i_c) != 6'd63) begin
                                if (has_longer(i_c)) begin
                                    m = M_OP; pc0 = i_c; pcnt = 2'd1;
                                end else begin
                                    rec[n] = '{K_OP, op1(i_c), wo(p), 32'd1, ls, 64'd0, 1'b0,
                                               E_NONE};
                                    n = n + 1'b1; ls = 1'b0;
                                end
                            end else begin
                                rec[n] = '{K_UNK, 6'd0, wo(p), 32'd1, ls, 64'd0, 1'b0, E_UNK};
                                n = n + 1'b1; ls = 1'b0;
                            end
                        end
                    end
                    M_SLASH: begin
                        if (i_c == 16'h2f) begin
                            m = M_LINE; pc0 = 16'(LK_NONE); pcnt = 2'd2;
                        end else if (i_c == 16'h2a) begin
                            m = M_BLOCK; pcnt = 2'd0;
                        end else if (i_c == 16'h3d) begin
                            rec[n] = '{K_OP, OP_DIV_EQ, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0,
                                       E_NONE};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE;
                        end else begin
                            rec[n] = '{K_OP, OP_DIV, wo(ts), wo(p - ts), ls, 64'd0, 1'b0,
                                       E_NONE};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                        end
                    end
                    M_LINE: begin
                        done = 1'b0;
                        if (pcnt == 2'd2) begin
                            if (i_c == 16'h2f) begin pcnt = 2'd3; done = 1'b1; end
                            else pcnt = 2'd0;
                        end else if (pcnt == 2'd3) begin
                            pcnt = 2'd0;
                            if (i_c == 16'h2f) begin pc0 = 16'(LK_NONE); done = 1'b1; end
                            else pc0 = 16'(LK_DOC);
                        end
                        if (!done && is_eol(i_c)) begin
                            if ((pc0 == 16'(LK_DOC) && i_doc_en) ||
                                (pc0 == 16'(LK_DIR) && i_dir_en)) begin
                                rec[n] = '{(pc0 == 16'(LK_DOC)) ? K_DOC : K_DIR, 6'd0, wo(ts),
                                           wo(p - ts), ls, 64'd0, 1'b0, E_NONE};
                                n = n + 1'b1;
                            end
                            ls = 1'b0; m = M_IDLE; redo = 1'b1;
                        end
                    end
                    M_BLOCK: begin
                        if (pcnt != 2'd0 && i_c == 16'h2f) begin
                            ls = 1'b0; m = M_IDLE;
                        end else pcnt = (i_c == 16'h2a) ? 2'd1 : 2'd0;
                    end
                    M_STR: begin
                        if (pcnt != 2'd0) begin
                            pcnt = 2'd0;
                            if (is_eol(i_c)) begin
                                rec[n] = '{K_STR, 6'd0, wo(ts), wo(p - ts), ls, 64'd0, 1'b0,
                                           E_OPENSTR};
                                n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                            end else if (!good_escape(i_c)) begin
                                rec[n] = '{K_DIAG, 6'd0, wo(p - 1'b1), 32'd2, 1'b0, 64'd0,
                                           1'b0, E_BADESC};
                                n = n + 1'b1;
                            end
                        end else if (is_eol(i_c)) begin
                            rec[n] = '{K_STR, 6'd0, wo(ts), wo(p - ts), ls, 64'd0, 1'b0,
                                       E_OPENSTR};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                        end else if (i_c == 16'h22) begin
                            rec[n] = '{K_STR, 6'd0, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0,
                                       E_NONE};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE;
                        end else if (i_c == 16'h5c) pcnt = 2'd1;
                    end
                    M_NUM: begin
                        // phase walk: each phase falls only to later ones
                        ph = pc0[3:0];
                        done = 1'b0;
                        if (ph == PH_ZERO) begin
                            if (i_c == 16'h78 || i_c == 16'h58) begin
                                nf[F_HEX] = 1'b1; ph = PH_HEX0; done = 1'b1;
                            end else ph = PH_DEC;
                        end
                        if (!done && (ph == PH_HEX0 || ph == PH_HEX)) begin
                            if (is_hexd(i_c)) begin
                                acc = {acc[59:0], hex_val(i_c)}; ph = PH_HEX; done = 1'b1;
                            end else begin
                                if (ph == PH_HEX0) nf[F_BAD] = 1'b1;
                                ph = PH_SUF;
                            end
                        end
                        if (!done && ph == PH_DEC) begin
                            if (is_digit(i_c)) begin
                                acc = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} +
                                      64'(i_c[3:0]);
                                done = 1'b1;
                            end else if (i_c == 16'h2e) begin
                                nf[F_FE] = 1'b1; ph = PH_FRAC; done = 1'b1;
                            end else ph = PH_ECHK;
                        end
                        if (!done && ph == PH_FRAC) begin
                            if (is_digit(i_c)) done = 1'b1;
                            else ph = PH_ECHK;
                        end
                        if (!done && ph == PH_ECHK) begin
                            if (i_c == 16'h65 || i_c == 16'h45) begin
                                nf[F_FE] = 1'b1; ph = PH_E; done = 1'b1;
                            end else ph = PH_SUF;
                        end
                        if (!done && ph == PH_E) begin
                            if (i_c == 16'h2b || i_c == 16'h2d) begin
                                ph = PH_ESIGN; done = 1'b1;
                            end else if (is_digit(i_c)) begin
                                ph = PH_EXP; done = 1'b1;
                            end else begin
                                nf[F_BAD] = 1'b1; ph = PH_SUF;
                            end
                        end
                        if (!done && ph == PH_ESIGN) begin
                            if (is_digit(i_c)) begin ph = PH_EXP; done = 1'b1; end
                            else begin nf[F_BAD] = 1'b1; ph = PH_SUF; end
                        end
                        if (!done && ph == PH_EXP) begin
                            if (is_digit(i_c)) done = 1'b1;
                            else ph = PH_SUF;
                        end
                        if (!done && ph == PH_SUF) begin
                            if (is_suffix(i_c)) begin
                                if (is_fsuf(i_c)) nf[F_FS] = 1'b1;
                                else nf[F_IS] = 1'b1;
                                if (is_usuf(i_c)) nf[F_U] = 1'b1;
                                done = 1'b1;
                            end else ph = PH_GLUE;
                        end
                        if (!done && ph == PH_GLUE) begin
                            if (is_idc(i_c) || i_c == 16'h2e) begin
                                nf[F_BAD] = 1'b1; done = 1'b1;
                            end
                        end
                        if (!done && ph > PH_GLUE) ph = PH_GLUE;
                        pc0 = 16'(ph);
                        if (!done) begin
                            f = nf;
                            if (f[F_FS] && f[F_IS]) f[F_BAD] = 1'b1;
                            if (f[F_IS] && f[F_FE]) f[F_BAD] = 1'b1;
                            if (f[F_HEX] && f[F_FS]) f[F_BAD] = 1'b1;
                            isf = !f[F_HEX] && (f[F_FE] || f[F_FS]);
                            rec[n] = '{isf ? K_FLOAT : K_INT, 6'd0, wo(ts), wo(p - ts), ls,
                                       isf ? 64'd0 : acc, !isf && f[F_U],
                                       f[F_BAD] ? E_BADNUM : E_NONE};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (!is_idc(i_c)) begin
                            rec[n] = '{K_IDENT, 6'd0, wo(ts), wo(p - ts), ls, 64'd0, 1'b0,
                                       E_NONE};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                        end
                    end
                    M_OP: begin
                        if (pcnt == 2'd2) begin
                            if (i_c == 16'h3d) begin
                                rec[n] = '{K_OP, (pc0 == 16'h3c) ? OP_SHL_EQ : OP_SHR_EQ,
                                           wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0, E_NONE};
                                n = n + 1'b1; ls = 1'b0; m = M_IDLE;
                            end else begin
                                rec[n] = '{K_OP, (pc0 == 16'h3c) ? OP_SHL : OP_SHR, wo(ts),
                                           wo(p - ts), ls, 64'd0, 1'b0, E_NONE};
                                n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                            end
                        end else if ((pc0 == 16'h3c || pc0 == 16'h3e) && i_c == pc0) begin
                            pcnt = 2'd2;
                        end else begin
                            k = op2(pc0[7:0], i_c);
                            if (k != 6'd63) begin
                                rec[n] = '{K_OP, k, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0,
                                           E_NONE};
                                n = n + 1'b1; ls = 1'b0; m = M_IDLE;
                            end else begin
                                rec[n] = '{K_OP, op1(pc0), wo(ts), wo(p - ts), ls, 64'd0,
                                           1'b0, E_NONE};
                                n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                            end
                        end
                    end
                    M_DOT: begin
                        if (is_digit(i_c)) begin
                            m = M_NUM; acc = '0; nf = '0; nf[F_FE] = 1'b1;
                            pc0 = 16'(PH_FRAC);
                        end else begin
                            rec[n] = '{K_OP, OP_DOT, wo(ts), wo(p - ts), ls, 64'd0, 1'b0,
                                       E_NONE};
                            n = n + 1'b1; ls = 1'b0; m = M_IDLE; redo = 1'b1;
                        end
                    end
                    default: begin
                        m = M_IDLE; redo = 1'b1;
                    end
                endcase
            end
        end

        // end of text: flush the open token, then the eof record if fewer than three are formed
        if (i_last) begin
            case (m)
                M_SLASH: begin
                    rec[n] = '{K_OP, OP_DIV, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0, E_NONE};
                    n = n + 1'b1; ls = 1'b0;
                end
                M_LINE: begin
                    if (pcnt == 2'd3) pc0 = 16'(LK_DOC);
                    if ((pc0 == 16'(LK_DOC) && i_doc_en) || (pc0 == 16'(LK_DIR) && i_dir_en))
                    begin
                        rec[n] = '{(pc0 == 16'(LK_DOC)) ? K_DOC : K_DIR, 6'd0, wo(ts),
                                   wo(p1 - ts), ls, 64'd0, 1'b0, E_NONE};
                        n = n + 1'b1;
                    end
                    ls = 1'b0;
                end
                M_BLOCK: begin
                    rec[n] = '{K_DIAG, 6'd0, wo(ts), 32'd2, 1'b0, 64'd0, 1'b0, E_OPENCMT};
                    n = n + 1'b1; ls = 1'b0;
                end
                M_STR: begin
                    rec[n] = '{K_STR, 6'd0, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0, E_OPENSTR};
                    n = n + 1'b1; ls = 1'b0;
                end
                M_NUM: begin
                    f = nf;
                    if (pc0 == 16'(PH_HEX0) || pc0 == 16'(PH_E) || pc0 == 16'(PH_ESIGN))
                        f[F_BAD] = 1'b1;
                    if (f[F_FS] && f[F_IS]) f[F_BAD] = 1'b1;
                    if (f[F_IS] && f[F_FE]) f[F_BAD] = 1'b1;
                    if (f[F_HEX] && f[F_FS]) f[F_BAD] = 1'b1;
                    isf = !f[F_HEX] && (f[F_FE] || f[F_FS]);
                    rec[n] = '{isf ? K_FLOAT : K_INT, 6'd0, wo(ts), wo(p1 - ts), ls,
                               isf ? 64'd0 : acc, !isf && f[F_U],
                               f[F_BAD] ? E_BADNUM : E_NONE};
                    n = n + 1'b1; ls = 1'b0;
                end
                M_IDENT: begin
                    rec[n] = '{K_IDENT, 6'd0, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0, E_NONE};
                    n = n + 1'b1; ls = 1'b0;
                end
                M_OP: begin
                    rec[n] = '{K_OP, (pcnt == 2'd2) ? ((pc0 == 16'h3c) ? OP_SHL : OP_SHR)
                               : op1(pc0), wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0, E_NONE};
                    n = n + 1'b1; ls = 1'b0;
                end
                M_DOT: begin
                    rec[n] = '{K_OP, OP_DOT, wo(ts), wo(p1 - ts), ls, 64'd0, 1'b0, E_NONE};
                    n = n + 1'b1; ls = 1'b0;
                end
                default: ;
            endcase
            if (n != 2'd3) begin
                rec[n] = '{K_EOF, 6'd0, wo(p1), 32'd0, ls, 64'd0, 1'b0, E_NONE};
                n = n + 1'b1;
            end
        end

        b.n = n; b.r0 = rec[0]; b.r1 = rec[1]; b.r2 = rec[2];
        n_mode = m; n_ls = ls; n_tstart = ts; n_acc = acc; n_nf = nf;
        n_pc0 = pc0; n_pcnt = pcnt;
    end

    assign o_bundle = b;

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_ls <= 1'b1; r_tstart <= '0; r_pos <= '0;
            r_acc <= '0; r_nf <= '0; r_pc0 <= '0; r_pcnt <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_mode <= M_IDLE; r_ls <= 1'b1; r_tstart <= '0; r_pos <= '0;
                r_acc <= '0; r_nf <= '0; r_pc0 <= '0; r_pcnt <= '0;
            end else begin
                r_mode <= n_mode; r_ls <= n_ls; r_tstart <= n_tstart;
                r_pos <= r_pos + 1'b1; r_acc <= n_acc; r_nf <= n_nf;
                r_pc0 <= n_pc0; r_pcnt <= n_pcnt;
            end
        end
    end
endmodule

[src/sst_back.sv]
// Record queue and serialiser: one request bundle becomes one to three records.
module sst_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sst_pkg::t_bundle i_bundle,
    output logic             o_can_push,
    sst_out_if.source        out
);
    import sst_pkg::*;

    localparam int DEPTH = 4;

    t_bundle    r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] r_sub;
    t_bundle    hd;
    t_rec       cur;
    logic       pop_rec, pop_b, is_last;

    assign hd = r_q[r_rp];
    always_comb begin
        case (r_sub)
            2'd0: cur = hd.r0;
            2'd1: cur = hd.r1;
            default: cur = hd.r2;
        endcase
    end
    assign is_last = (r_sub + 1'b1) == hd.n;
    assign pop_rec = out.valid && out.ready;
    assign pop_b = pop_rec && is_last;
    assign o_can_push = (r_cnt != 3'(DEPTH)) || pop_b;

    assign out.valid = r_cnt != 3'd0;
    assign out.token_kind = cur.kind;
    assign out.operator_code = cur.op;
    assign out.span_start = cur.start;
    assign out.span_length = cur.len;
    assign out.at_line_start = cur.ls;
    assign out.integer_value = cur.val;
    assign out.is_unsigned = cur.uns;
    assign out.error_code = cur.err;
    assign out.last_of_run = is_last;

    // bundle payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
    end

    // queue pointers and record index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop_b) begin
                r_rp <= r_rp + 1'b1; r_sub <= '0;
            end else if (pop_rec) r_sub <= r_sub + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(pop_b);
        end
    end
endmodule

[src/shader_source_tokenizer_top.sv]
// Shader source tokenizer.
// Input channel: one 16-bit code unit per request, end_of_text on the last one
// of a text. Output channel: token records (kind, operator, span, line-start,
// integer value, unsigned flag, error code, last_of_run on the final record
// of each input request). An input that closes nothing yields no record.
// Throughput: one code unit per cycle while records drain as fast as they
// form; the output port delivers one record per cycle while the receiver is
// ready, so units producing two or three records (token end plus end of file,
// bad escape) drain over extra cycles through a four-entry bundle queue.
// Latency: with the queue empty, a unit's first record appears the cycle after
// it is accepted; otherwise it waits behind the records already queued.
// Configuration: cfg_we/cfg_idx/cfg_data, register 0 enables doc comment
// records, register 1 enables directive records; both reset to 1.
// Reset (synchronous, active low) returns the lexer to idle at offset 0 and
// empties the queue. After end_of_text the lexer restarts at offset 0.
// When the receiver stalls, the queue fills and input ready drops.
module shader_source_tokenizer_top #(
    parameter int OFFSET_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data,
    sst_in_if.sink     in_ch,
    sst_out_if.source  out_ch
);
    import sst_pkg::*;

    logic     r_doc_en, r_dir_en;
    logic     can_push, take;
    t_bundle  bundle;

    assign in_ch.ready = can_push;
    assign take = in_ch.valid && can_push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_en <= 1'b1; r_dir_en <= 1'b1;
        end else if (i_cfg_we) begin
            if ({1'b0, i_cfg_idx} == CFG_DOC) r_doc_en <= i_cfg_data;
            if ({1'b0, i_cfg_idx} == CFG_DIR) r_dir_en <= i_cfg_data;
        end
    end

    sst_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_c(in_ch.char_code), .i_last(in_ch.end_of_text),
        .i_doc_en(r_doc_en), .i_dir_en(r_dir_en), .o_bundle(bundle)
    );

    sst_back u_back (
        .i_clk, .i_rst_n, .i_push(take && bundle.n != 2'd0), .i_bundle(bundle),
        .o_can_push(can_push), .out(out_ch)
    );

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.token_kind == K_EOF |-> out_ch.last_of_run)
        else $error("eof record not last of run");
    a_eof_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.token_kind == K_EOF |-> out_ch.span_length == 32'd0)
        else $error("eof record with nonzero length");
    a_nonop_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.token_kind != K_OP |-> out_ch.operator_code == 6'd0)
        else $error("operator code on non-operator record");
endmodule

[verif/shader_source_tokenizer_top_tb.sv]
`timescale 1ns / 100ps

module shader_source_tokenizer_top_tb;
    import sst_pkg::*;

    localparam logic [3:0]  NO_KIND    = 4'hF;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          RAND_UNITS = 500;
    localparam logic [15:0] CH_LF      = 16'h0a;
    localparam logic [15:0] CH_CR      = 16'h0d;

    typedef struct {
        logic [3:0]  kind;
        logic [5:0]  op;
        logic [31:0] start;
        logic [31:0] len;
        bit          ls;
        logic [63:0] val;
        bit          uns;
        logic [2:0]  err;
        bit          last;
    } t_token;

    typedef struct {
        logic [15:0] c;
        bit          eot;
        logic [3:0]  kind;
        logic [2:0]  err;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic i_cfg_data = 1'b0;

    sst_in_if  in_ch ();
    sst_out_if out_ch ();

    shader_source_tokenizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // operator spellings, longest first; position is the operator code
    string op_txt[44] = '{
        "<<=", ">>=", "++", "--", "&&", "||", "==", "!=", "<=", ">=", "+=",
        "-=", "*=", "/=", "%=", "&=", "|=", "^=", "<<", ">>", "(", ")", "{",
        "}", "[", "]", ",", ";", ":", ".", "?", "+", "-", "*", "/", "%", "&",
        "|", "^", "~", "!", "<", ">", "="
    };

    // directed opening: line kinds, error cases, operators, suffix
    t_dir_row dir_rows[25] = '{
        '{"#", 0, NO_KIND, E_NONE},   '{"x", 0, NO_KIND, E_NONE},
        '{CH_LF, 0, K_DIR, E_NONE},   '{"a", 0, NO_KIND, E_NONE},
        '{"#", 0, K_IDENT, E_NONE},   '{16'hffff, 0, K_UNK, E_UNK},
        '{16'h0000, 0, K_UNK, E_UNK}, '{"\"", 0, NO_KIND, E_NONE},
        '{"\\", 0, NO_KIND, E_NONE},  '{"q", 0, K_DIAG, E_BADESC},
        '{CH_LF, 0, K_STR, E_OPENSTR}, '{"0", 0, NO_KIND, E_NONE},
        '{"x", 0, NO_KIND, E_NONE},   '{"/", 0, K_INT, E_BADNUM},
        '{"*", 1, K_DIAG, E_OPENCMT}, '{"/", 0, NO_KIND, E_NONE},
        '{"/", 0, NO_KIND, E_NONE},   '{"/", 0, NO_KIND, E_NONE},
        '{"d", 0, NO_KIND, E_NONE},   '{CH_LF, 0, K_DOC, E_NONE},
        '{"<", 0, NO_KIND, E_NONE},   '{"<", 0, NO_KIND, E_NONE},
        '{"=", 0, K_OP, E_NONE},      '{"9", 0, NO_KIND, E_NONE},
        '{"u", 1, K_INT, E_NONE}
    };

    // lexer image kept by the predictor
    bit          cfg_doc = 1'b1;
    bit          cfg_dir = 1'b1;
    t_mode       lx_mode = M_IDLE;
    bit          lx_ls = 1'b1;
    logic [31:0] lx_tstart = '0;
    logic [31:0] lx_pos = '0;
    logic [63:0] lx_acc = '0;
    logic [5:0]  lx_nf = '0;
    logic [15:0] lx_p0 = '0;
    logic [15:0] lx_p1 = '0;
    int          lx_pcnt = 0;
    t_token      unit_toks[$];
    t_token      exp_tokens[$];

    int          fail_count = 0;
    int          idle_cycles = 0;
    logic [3:0]  cur_kind = NO_KIND;
    logic [2:0]  cur_err = E_NONE;
    bit          drv_on = 1'b0;
    int          burst_left = 4;
    bit          gaps_on = 1'b1;
    int          stall_pct = 0;
    int          rx_cycles = 0;
    logic [15:0] text_buf[$];

    // character classes
    function automatic bit ch_digit(logic [15:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit ch_hex(logic [15:0] c);
        return ch_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic logic [63:0] ch_hexval(logic [15:0] c);
        if (ch_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return (c - "A" + 10) & 15;
    endfunction
    function automatic bit ch_idstart(logic [15:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction
    function automatic bit ch_id(logic [15:0] c);
        return ch_idstart(c) || ch_digit(c);
    endfunction
    function automatic bit ch_fsuf(logic [15:0] c);
        return c == "f" || c == "F" || c == "h" || c == "H";
    endfunction
    function automatic bit ch_suffix(logic [15:0] c);
        return ch_fsuf(c) || c == "u" || c == "U" || c == "l" || c == "L";
    endfunction
    function automatic bit ch_eol(logic [15:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction
    function automatic bit ch_blank(logic [15:0] c);
        return c == " " || c == 16'h09 || c == 16'h0b || c == 16'h0c;
    endfunction
    function automatic bit ch_escape_ok(logic [15:0] c);
        return c == "\\" || c == "\"" || c == "n" || c == "r" || c == "t" || c == "0";
    endfunction

    function automatic int op_lookup(logic [15:0] a, logic [15:0] b, int n);
        for (int i = 0; i < 44; i++) begin
            if (op_txt[i].len() != n) continue;
            if ({8'h00, op_txt[i][0]} != a) continue;
            if (n > 1 && {8'h00, op_txt[i][1]} != b) continue;
            return i;
        end
        return -1;
    endfunction

    function automatic bit op_extends(logic [15:0] c);
        for (int i = 0; i < 20; i++)
            if ({8'h00, op_txt[i][0]} == c) return 1'b1;
        return 1'b0;
    endfunction

    // record building
    function automatic void add_tok(logic [3:0] k, int op, logic [31:0] s, logic [31:0] e,
                                    bit ls, logic [63:0] v, bit u, logic [2:0] er);
        t_token t;
        if (unit_toks.size() >= 3) return;
        t.kind = k; t.op = op[5:0]; t.start = s; t.len = e - s; t.ls = ls;
        t.val = v; t.uns = u; t.err = er; t.last = 1'b0;
        unit_toks.push_back(t);
    endfunction

    function automatic void close_tok(logic [3:0] k, int op, logic [31:0] e, logic [63:0] v,
                                      bit u, logic [2:0] er);
        add_tok(k, (op < 0) ? 0 : op, lx_tstart, e, lx_ls, v, u, er);
        lx_ls = 1'b0;
        lx_mode = M_IDLE;
    endfunction

    function automatic void close_line(logic [31:0] e);
        if ((lx_p0 == LK_DOC && cfg_doc) || (lx_p0 == LK_DIR && cfg_dir))
            close_tok((lx_p0 == LK_DOC) ? K_DOC : K_DIR, 0, e, 0, 0, E_NONE);
        lx_ls = 1'b0;
        lx_mode = M_IDLE;
    endfunction

    function automatic void num_done(logic [31:0] e);
        logic [5:0] f;
        bit         isf;
        f = lx_nf;
        if (f[F_FS] && f[F_IS]) f[F_BAD] = 1'b1;
        if (f[F_IS] && f[F_FE]) f[F_BAD] = 1'b1;
        if (f[F_HEX] && f[F_FS]) f[F_BAD] = 1'b1;
        isf = !f[F_HEX] && (f[F_FE] || f[F_FS]);
        close_tok(isf ? K_FLOAT : K_INT, 0, e, isf ? 64'd0 : lx_acc, !isf && f[F_U],
                  f[F_BAD] ? E_BADNUM : E_NONE);
    endfunction

    // number phase walk; 1 when the unit belongs to the number
    function automatic bit num_take(logic [15:0] c, logic [31:0] p);
        logic [3:0] ph;
        ph = lx_p0[3:0];
        while (1) begin
            lx_p0 = ph;
            case (ph)
                PH_ZERO: begin
                    if (c == "x" || c == "X") begin
                        lx_nf[F_HEX] = 1'b1; lx_p0 = PH_HEX0; return 1'b1;
                    end
                    ph = PH_DEC;
                end
                PH_HEX0, PH_HEX: begin
                    if (ch_hex(c)) begin
                        lx_acc = lx_acc * 16 + ch_hexval(c); lx_p0 = PH_HEX; return 1'b1;
                    end
                    if (ph == PH_HEX0) lx_nf[F_BAD] = 1'b1;
                    ph = PH_SUF;
                end
                PH_DEC: begin
                    if (ch_digit(c)) begin
                        lx_acc = lx_acc * 10 + (c - "0"); return 1'b1;
                    end
                    if (c == ".") begin
                        lx_nf[F_FE] = 1'b1; lx_p0 = PH_FRAC; return 1'b1;
                    end
                    ph = PH_ECHK;
                end
                PH_FRAC: begin
                    if (ch_digit(c)) return 1'b1;
                    ph = PH_ECHK;
                end
                PH_ECHK: begin
                    if (c == "e" || c == "E") begin
                        lx_nf[F_FE] = 1'b1; lx_p0 = PH_E; return 1'b1;
                    end
                    ph = PH_SUF;
                end
                PH_E: begin
                    if (c == "+" || c == "-") begin lx_p0 = PH_ESIGN; return 1'b1; end
                    if (ch_digit(c)) begin lx_p0 = PH_EXP; return 1'b1; end
                    lx_nf[F_BAD] = 1'b1; ph = PH_SUF;
                end
                PH_ESIGN: begin
                    if (ch_digit(c)) begin lx_p0 = PH_EXP; return 1'b1; end
                    lx_nf[F_BAD] = 1'b1; ph = PH_SUF;
                end
                PH_EXP: begin
                    if (ch_digit(c)) return 1'b1;
                    ph = PH_SUF;
                end
                PH_SUF: begin
                    if (ch_suffix(c)) begin
                        if (ch_fsuf(c)) lx_nf[F_FS] = 1'b1;
                        else lx_nf[F_IS] = 1'b1;
                        if (c == "u" || c == "U") lx_nf[F_U] = 1'b1;
                        return 1'b1;
                    end
                    ph = PH_GLUE;
                end
                PH_GLUE: begin
                    if (ch_id(c) || c == ".") begin lx_nf[F_BAD] = 1'b1; return 1'b1; end
                    num_done(p);
                    return 1'b0;
                end
                default: begin
                    num_done(p);
                    return 1'b0;
                end
            endcase
        end
        return 1'b0;
    endfunction

    function automatic void op_shut(logic [31:0] e);
        if (lx_pcnt == 2) close_tok(K_OP, (lx_p0 == "<") ? OP_SHL : OP_SHR, e, 0, 0, E_NONE);
        else close_tok(K_OP, op_lookup(lx_p0, 0, 1), e, 0, 0, E_NONE);
    endfunction

    function automatic void idle_start(logic [15:0] c, logic [31:0] p);
        int k;
        if (ch_eol(c)) begin lx_ls = 1'b1; return; end
        if (ch_blank(c)) return;
        lx_tstart = p;
        if (c == "/") begin lx_mode = M_SLASH; return; end
        if (c == "#") begin
            if (!lx_ls) begin add_tok(K_UNK, 0, p, p + 1, 0, 0, 0, E_HASH); return; end
            lx_mode = M_LINE; lx_p0 = LK_DIR; lx_pcnt = 0; return;
        end
        if (c == "\"") begin lx_mode = M_STR; lx_pcnt = 0; return; end
        if (ch_digit(c)) begin
            lx_mode = M_NUM; lx_acc = c - "0"; lx_nf = '0;
            lx_p0 = (c == "0") ? PH_ZERO : PH_DEC; return;
        end
        if (c == ".") begin lx_mode = M_DOT; return; end
        if (ch_idstart(c)) begin lx_mode = M_IDENT; return; end
        k = op_lookup(c, 0, 1);
        if (k >= 0) begin
            if (op_extends(c)) begin lx_mode = M_OP; lx_p0 = c; lx_pcnt = 1; return; end
            close_tok(K_OP, k, p + 1, 0, 0, E_NONE); return;
        end
        close_tok(K_UNK, 0, p + 1, 0, 0, E_UNK);
    endfunction

    function automatic void lex_unit(logic [15:0] c, logic [31:0] p);
        int k;
        while (1) begin
            case (lx_mode)
                M_IDLE: begin idle_start(c, p); return; end
                M_SLASH: begin
                    if (c == "/") begin
                        lx_mode = M_LINE; lx_p0 = LK_NONE; lx_pcnt = 2; return;
                    end
                    if (c == "*") begin lx_mode = M_BLOCK; lx_pcnt = 0; return; end
                    if (c == "=") begin close_tok(K_OP, OP_DIV_EQ, p + 1, 0, 0, E_NONE); return; end
                    close_tok(K_OP, OP_DIV, p, 0, 0, E_NONE);
                end
                M_LINE: begin
                    if (lx_pcnt == 2) begin
                        if (c == "/") begin lx_pcnt = 3; return; end
                        lx_pcnt = 0;
                    end else if (lx_pcnt == 3) begin
                        lx_pcnt = 0;
                        if (c == "/") begin lx_p0 = LK_NONE; return; end
                        lx_p0 = LK_DOC;
                    end
                    if (!ch_eol(c)) return;
                    close_line(p);
                end
                M_BLOCK: begin
                    if (lx_pcnt != 0 && c == "/") begin
                        lx_ls = 1'b0; lx_mode = M_IDLE; return;
                    end
                    lx_pcnt = (c == "*") ? 1 : 0;
                    return;
                end
                M_STR: begin
                    if (lx_pcnt != 0) begin
                        lx_pcnt = 0;
                        if (!ch_eol(c)) begin
                            if (!ch_escape_ok(c)) add_tok(K_DIAG, 0, p - 1, p + 1, 0, 0, 0, E_BADESC);
                            return;
                        end
                        close_tok(K_STR, 0, p, 0, 0, E_OPENSTR);
                    end else if (ch_eol(c)) begin
                        close_tok(K_STR, 0, p, 0, 0, E_OPENSTR);
                    end else begin
                        if (c == "\"") close_tok(K_STR, 0, p + 1, 0, 0, E_NONE);
                        else if (c == "\\") lx_pcnt = 1;
                        return;
                    end
                end
                M_NUM: begin
                    if (num_take(c, p)) return;
                end
                M_IDENT: begin
                    if (ch_id(c)) return;
                    close_tok(K_IDENT, 0, p, 0, 0, E_NONE);
                end
                M_OP: begin
                    if (lx_pcnt == 2) begin
                        if (c == "=") begin
                            close_tok(K_OP, (lx_p0 == "<") ? OP_SHL_EQ : OP_SHR_EQ, p + 1, 0, 0,
                                      E_NONE);
                            return;
                        end
                        op_shut(p);
                    end else if ((lx_p0 == "<" || lx_p0 == ">") && c == lx_p0) begin
                        lx_p1 = c; lx_pcnt = 2; return;
                    end else begin
                        k = op_lookup(lx_p0, c, 2);
                        if (k >= 0) begin close_tok(K_OP, k, p + 1, 0, 0, E_NONE); return; end
                        op_shut(p);
                    end
                end
                M_DOT: begin
                    if (ch_digit(c)) begin
                        lx_mode = M_NUM; lx_acc = '0; lx_nf = '0; lx_nf[F_FE] = 1'b1;
                        lx_p0 = PH_FRAC; return;
                    end
                    close_tok(K_OP, OP_DOT, p, 0, 0, E_NONE);
                end
                default: lx_mode = M_IDLE;
            endcase
        end
    endfunction

    // end of text: close what is open, then the end-of-file record if fewer than three are held
    function automatic void text_end(logic [31:0] e);
        case (lx_mode)
            M_SLASH: close_tok(K_OP, OP_DIV, e, 0, 0, E_NONE);
            M_LINE: begin
                if (lx_pcnt == 3) lx_p0 = LK_DOC;
                close_line(e);
            end
            M_BLOCK: begin
                add_tok(K_DIAG, 0, lx_tstart, lx_tstart + 2, 0, 0, 0, E_OPENCMT);
                lx_ls = 1'b0;
            end
            M_STR: close_tok(K_STR, 0, e, 0, 0, E_OPENSTR);
            M_NUM: begin
                if (lx_p0 == PH_HEX0 || lx_p0 == PH_E || lx_p0 == PH_ESIGN) lx_nf[F_BAD] = 1'b1;
                num_done(e);
            end
            M_IDENT: close_tok(K_IDENT, 0, e, 0, 0, E_NONE);
            M_OP: op_shut(e);
            M_DOT: close_tok(K_OP, OP_DOT, e, 0, 0, E_NONE);
            default: ;
        endcase
        add_tok(K_EOF, 0, e, e, lx_ls, 0, 0, E_NONE);
    endfunction

    function automatic void lex_clear();
        lx_mode = M_IDLE; lx_ls = 1'b1; lx_tstart = '0; lx_pos = '0; lx_acc = '0;
        lx_nf = '0; lx_p0 = '0; lx_p1 = '0; lx_pcnt = 0;
    endfunction

    // tokens caused by one accepted unit, queued as expectations
    function automatic void predict_tokens(logic [15:0] c, bit eot, logic [3:0] tk,
                                           logic [2:0] te);
        logic [31:0] p;
        p = lx_pos;
        unit_toks.delete();
        lex_unit(c, p);
        lx_pos = p + 1;
        if (eot) begin
            text_end(lx_pos);
            lex_clear();
        end
        if (unit_toks.size() > 0) begin
            unit_toks[unit_toks.size() - 1].last = 1'b1;
            if (tk != NO_KIND) begin
                unit_toks[0].kind = tk;
                unit_toks[0].err = te;
            end
        end
        foreach (unit_toks[i]) exp_tokens.push_back(unit_toks[i]);
    endfunction

    function automatic bit same_tok(t_token a, t_token b);
        return a.kind === b.kind && a.op === b.op && a.start === b.start && a.len === b.len &&
               a.ls === b.ls && a.val === b.val && a.uns === b.uns && a.err === b.err &&
               a.last === b.last;
    endfunction

    function automatic void show_tok(string tag, t_token t);
        $display("  %s kind=%0d op=%0d start=%0d len=%0d ls=%0d val=%h uns=%0d err=%0d last=%0d",
                 tag, t.kind, t.op, t.start, t.len, t.ls, t.val, t.uns, t.err, t.last);
    endfunction

    // scoreboard, predictor update and watchdog
    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.kind = out_ch.token_kind; got.op = out_ch.operator_code;
                got.start = out_ch.span_start; got.len = out_ch.span_length;
                got.ls = out_ch.at_line_start; got.val = out_ch.integer_value;
                got.uns = out_ch.is_unsigned; got.err = out_ch.error_code;
                got.last = out_ch.last_of_run;
                if (exp_tokens.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: token with nothing expected", $realtime);
                        show_tok("actual  ", got);
                    end
                end else begin
                    want = exp_tokens.pop_front();
                    if (!same_tok(want, got)) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: token mismatch", $realtime);
                            show_tok("expected", want);
                            show_tok("actual  ", got);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_tokens(in_ch.char_code, in_ch.end_of_text, cur_kind, cur_err);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress, giving up", $realtime);
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver: stall rate changes every so often, sometimes no stalls at all
    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 150 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        out_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    // one request on the input channel; called at a falling edge
    task automatic send_unit(logic [15:0] c, bit eot, logic [3:0] tk, logic [2:0] te);
        in_ch.valid <= 1'b1;
        in_ch.char_code <= c;
        in_ch.end_of_text <= eot;
        cur_kind = tk;
        cur_err = te;
        drv_on = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            if (gaps_on) begin
                in_ch.valid <= 1'b0;
                drv_on = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    // stop sending and let every expected token drain
    task automatic drain_all();
        if (drv_on) begin
            in_ch.valid <= 1'b0;
            drv_on = 1'b0;
        end
        while (exp_tokens.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_regs(bit doc, bit dir);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DOC[0];
        i_cfg_data <= doc;
        @(negedge i_clk);
        cfg_doc = doc;
        i_cfg_idx <= CFG_DIR[0];
        i_cfg_data <= dir;
        @(negedge i_clk);
        cfg_dir = dir;
        i_cfg_we <= 1'b0;
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back({8'h00, s[i]});
    endfunction

    function automatic void push_rand(string pool, int n);
        repeat (n) text_buf.push_back({8'h00, pool[$urandom_range(0, pool.len() - 1)]});
    endfunction

    // one randomly chosen fragment of source text
    function automatic void add_fragment();
        string digs;
        string hexs;
        string idc;
        digs = "0123456789";
        hexs = "0123456789abcdefABCDEF";
        idc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        case ($urandom_range(0, 15))
            0, 13: begin
                push_rand("abcxyzQRS_", 1);
                push_rand(idc, $urandom_range(0, 6));
            end
            1: begin
                push_rand("123456789", 1);
                push_rand(digs, ($urandom_range(0, 7) == 0) ? 22 : $urandom_range(0, 4));
                if ($urandom_range(0, 2) == 0) push_rand("uUlLfhe", 1);
            end
            2: begin
                push_str($urandom_range(0, 1) ? "0x" : "0X");
                push_rand(hexs, ($urandom_range(0, 5) == 0) ? 18 : $urandom_range(0, 5));
                if ($urandom_range(0, 2) == 0) push_rand("uUlLfg", 1);
            end
            3: begin
                push_rand(digs, $urandom_range(0, 3));
                push_str(".");
                push_rand(digs, $urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    push_rand("eE", 1);
                    if ($urandom_range(0, 1)) push_rand("+-", 1);
                    push_rand(digs, $urandom_range(0, 2));
                end
                if ($urandom_range(0, 1)) push_rand("fFhHu", 1);
            end
            4: begin
                push_str("\"");
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_str("\\");
                        push_rand("\\\"nrt0qx\n", 1);
                    end else begin
                        push_rand("ab #/*9 ", 1);
                    end
                end
                if ($urandom_range(0, 4) != 0) push_str("\"");
            end
            5, 14: push_str(op_txt[$urandom_range(0, 43)]);
            6, 15: push_rand(" \t\v\f", $urandom_range(1, 2));
            7: begin
                case ($urandom_range(0, 2))
                    0: text_buf.push_back(CH_LF);
                    1: text_buf.push_back(CH_CR);
                    default: begin text_buf.push_back(CH_CR); text_buf.push_back(CH_LF); end
                endcase
                if ($urandom_range(0, 1)) push_rand(" \t", 1);
            end
            8: begin
                push_str("//");
                push_rand("ab /*x", $urandom_range(0, 4));
                text_buf.push_back(CH_LF);
            end
            9: begin
                push_str($urandom_range(0, 3) == 0 ? "////" : "///");
                push_rand("doc ", $urandom_range(0, 4));
                if ($urandom_range(0, 3) != 0) text_buf.push_back(CH_LF);
            end
            10: begin
                text_buf.push_back(CH_LF);
                push_str("#");
                push_rand("definclude 1", $urandom_range(0, 5));
                if ($urandom_range(0, 3) != 0) text_buf.push_back(CH_LF);
            end
            11: begin
                push_str("/*");
                push_rand("a*/ \n", $urandom_range(0, 5));
                if ($urandom_range(0, 3) != 0) push_str("*/");
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(16'($urandom_range(0, 65535)));
                    1: text_buf.push_back(16'($urandom_range(0, 127)));
                    2: push_str("#");
                    default: push_rand("@$`'.", 1);
                endcase
            end
        endcase
    endfunction

    task automatic send_text();
        text_buf.delete();
        repeat ($urandom_range(8, 24)) add_fragment();
        foreach (text_buf[i])
            send_unit(text_buf[i], i == text_buf.size() - 1, NO_KIND, E_NONE);
    endtask

    initial begin
        int sent;
        bit [1:0] modes[4];
        in_ch.valid = 1'b0;
        in_ch.char_code = '0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready = 1'b0;
        modes = '{2'b11, 2'b00, 2'b10, 2'b01};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows with registers at their reset values
        foreach (dir_rows[i])
            send_unit(dir_rows[i].c, dir_rows[i].eot, dir_rows[i].kind, dir_rows[i].err);

        // random texts over every register setting
        sent = 0;
        foreach (modes[m]) begin
            drain_all();
            set_regs(modes[m][1], modes[m][0]);
            gaps_on = (m != 2);
            while (sent < (m + 1) * RAND_UNITS / 4) begin
                send_text();
                sent += text_buf.size();
            end
        end

        drain_all();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
src/sst_pkg.sv
src/sst_if.sv
src/sst_front.sv
src/sst_back.sv
src/shader_source_tokenizer_top.sv
verif/shader_source_tokenizer_top_tb.sv
